FILE: rtl/swc_pkg.sv
// shared constants and types for the pd2 subtask window calculator
// no dependencies; used by swc_mul, swc_div and pd2_subtask_window_calc_unit
`default_nettype none

package swc_pkg;

  // width of all quanta values, and of the full product
  localparam int QW    = 16;
  localparam int PW    = 2 * QW;
  localparam int CNT_W = $clog2(QW);

  // last step of a serial operation
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QW - 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXEC   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b1;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV1 = 5'b00100,
    ST_DIV2 = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/swc_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on swc_pkg
`default_nettype none

module swc_mul (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [swc_pkg::QW-1:0] mul_a,
  input  wire logic [swc_pkg::QW-1:0] mul_b,
  output logic                        done,
  output logic [swc_pkg::PW-1:0]      product
);

  logic                      busy;
  logic [swc_pkg::CNT_W-1:0] cnt;
  logic [swc_pkg::QW-1:0]    a_sr;
  logic [swc_pkg::QW-1:0]    b_q;
  logic [swc_pkg::PW-1:0]    acc;
  logic [swc_pkg::QW:0]      sum;

  // add the multiplicand into the upper half, then shift the whole word right
  always_comb begin
    sum = {1'b0, acc[swc_pkg::PW-1:swc_pkg::QW]} + (a_sr[0] ? {1'b0, b_q} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == swc_pkg::LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sr <= mul_a;
      b_q  <= mul_b;
      acc  <= '0;
    end else if (busy) begin
      a_sr <= a_sr >> 1;
      acc  <= {sum, acc[swc_pkg::QW-1:1]};
    end
  end

  assign product = acc;

endmodule

`default_nettype wire

FILE: rtl/swc_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// dividend upper half must be below the divisor; depends on swc_pkg
`default_nettype none

module swc_div (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [swc_pkg::PW-1:0] dividend,
  input  wire logic [swc_pkg::QW-1:0] divisor,
  output logic                        done,
  output logic [swc_pkg::QW-1:0]      quotient,
  output logic [swc_pkg::QW-1:0]      remainder
);

  logic                      busy;
  logic [swc_pkg::CNT_W-1:0] cnt;
  logic [swc_pkg::QW-1:0]    rem;
  logic [swc_pkg::QW-1:0]    lo;
  logic [swc_pkg::QW-1:0]    dvs;
  logic [swc_pkg::QW:0]      trial;
  logic                      fits;

  always_comb begin
    trial = {rem, lo[swc_pkg::QW-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == swc_pkg::LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // low half shifts out dividend bits and shifts in quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[swc_pkg::PW-1:swc_pkg::QW];
      lo  <= dividend[swc_pkg::QW-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? swc_pkg::QW'(trial - {1'b0, dvs}) : trial[swc_pkg::QW-1:0];
      lo  <= {lo[swc_pkg::QW-2:0], fits};
    end
  end

  assign quotient  = lo;
  assign remainder = rem;

endmodule

`default_nettype wire

FILE: rtl/pd2_subtask_window_calc_unit.sv
// PD2 subtask window calculator: release, deadline, b bit and group deadline
// a user who writes exec_quanta (index 0) and period_quanta (index 1) and then
// feeds subtask indices from E down to 1 gets one result transaction per input
// transaction. Each item goes through a 16-step serial multiply for (i-1)P, then
// two 16-step passes of the shared radix-2 divider for (i-1)P/E and iP/E, and
// its result is then loaded into the output register. The input is stalled
// whenever the sequencer is not idle, so a new item is accepted only once the
// last one is in the output register; a stalled result holds the sequencer in
// its done step. A bad index (zero or above E) skips the arithmetic and goes
// straight to the done step; its result, with all other fields zero, frees the
// input as it is loaded into the output register. The group deadline minimum
// is reloaded with P at index E, is zero for light tasks (2E < P), and is not
// touched by register writes or bad indices.
// depends on swc_pkg, swc_mul and swc_div
`default_nettype none

module pd2_subtask_window_calc_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration writes
  input  wire logic                          cfg_we,
  input  wire logic [swc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [swc_pkg::QW-1:0]        cfg_data,
  // input transaction
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [swc_pkg::QW-1:0]        subtask_index,
  // result transaction
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [swc_pkg::QW-1:0]             release_time,
  output logic [swc_pkg::QW-1:0]             deadline_time,
  output logic                               overlap_bit,
  output logic [swc_pkg::QW-1:0]             group_deadline,
  output logic                               index_error
);

  swc_pkg::state_t state, state_next;

  logic [swc_pkg::QW-1:0] exec_quanta;
  logic [swc_pkg::QW-1:0] period_quanta;
  logic [swc_pkg::QW-1:0] min_gd;
  logic [swc_pkg::QW-1:0] idx;
  logic                   err;
  logic [swc_pkg::QW-1:0] rel;

  logic                   in_take;
  logic                   idx_bad;
  logic                   out_free;
  logic                   finish;

  logic                   mul_done;
  logic [swc_pkg::PW-1:0] mul_prod;
  logic                   div_start;
  logic [swc_pkg::PW-1:0] div_num;
  logic                   div_done;
  logic [swc_pkg::QW-1:0] div_q;
  logic [swc_pkg::QW-1:0] div_r;

  // result logic
  logic [swc_pkg::QW-1:0] dl;
  logic                   light;
  logic                   is_last;
  logic                   b_bit;
  logic [swc_pkg::QW-1:0] gd;
  logic [swc_pkg::QW-1:0] min_next;
  logic [swc_pkg::QW-1:0] win_len;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      exec_quanta   <= swc_pkg::QW'(1);
      period_quanta <= swc_pkg::QW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        swc_pkg::CFG_EXEC:   exec_quanta   <= cfg_data;
        swc_pkg::CFG_PERIOD: period_quanta <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign in_stall = (state != swc_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign idx_bad  = (subtask_index == '0) || (subtask_index > exec_quanta);
  assign out_free = !out_valid || !out_stall;
  assign finish   = (state == swc_pkg::ST_DONE) && out_free;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      swc_pkg::ST_IDLE: if (in_take) begin
        state_next = idx_bad ? swc_pkg::ST_DONE : swc_pkg::ST_MUL;
      end
      swc_pkg::ST_MUL:  if (mul_done) state_next = swc_pkg::ST_DIV1;
      swc_pkg::ST_DIV1: if (div_done) state_next = swc_pkg::ST_DIV2;
      swc_pkg::ST_DIV2: if (div_done) state_next = swc_pkg::ST_DONE;
      swc_pkg::ST_DONE: if (out_free) state_next = swc_pkg::ST_IDLE;
      default:          state_next = swc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      idx <= subtask_index;
      err <= idx_bad;
    end
    if ((state == swc_pkg::ST_DIV1) && div_done) begin
      rel <= div_q;
    end
  end

  // (i-1) * P
  swc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (in_take && !idx_bad),
    .mul_a   (subtask_index - 1'b1),
    .mul_b   (period_quanta),
    .done    (mul_done),
    .product (mul_prod)
  );

  // first pass divides (i-1)P, second pass divides iP = (i-1)P + P
  assign div_start = ((state == swc_pkg::ST_MUL) && mul_done) ||
                     ((state == swc_pkg::ST_DIV1) && div_done);
  assign div_num   = (state == swc_pkg::ST_MUL) ? mul_prod
                   : mul_prod + {{swc_pkg::QW{1'b0}}, period_quanta};

  swc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_num),
    .divisor   (exec_quanta),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // deadline is the true ceiling, b bit and group deadline update
  always_comb begin
    dl       = div_q + {{(swc_pkg::QW-1){1'b0}}, (div_r != '0)};
    light    = {exec_quanta, 1'b0} < {1'b0, period_quanta};
    is_last  = (idx == exec_quanta);
    win_len  = dl - rel;
    min_next = is_last ? period_quanta : min_gd;
    b_bit    = 1'b0;
    gd       = '0;
    if (light) begin
      min_next = '0;
    end else begin
      b_bit = !is_last && (div_r != '0);
      gd    = min_next;
      if (!b_bit && (dl < min_next)) begin
        min_next = dl;
        gd       = dl;
      end
      if ((dl >= rel) && (win_len == swc_pkg::QW'(3)) && ((dl - 1'b1) < min_next)) begin
        min_next = dl - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gd <= swc_pkg::QW'(1);
    end else if (finish && !err) begin
      min_gd <= min_next;
    end
  end

  // output register, frees the sequencer while the result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      release_time   <= err ? '0 : rel;
      deadline_time  <= err ? '0 : dl;
      overlap_bit    <= err ? 1'b0 : b_bit;
      group_deadline <= err ? '0 : gd;
      index_error    <= err;
    end
  end

  // checks
  a_mul_in_seq: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == swc_pkg::ST_MUL)
    else $error("multiplier finished outside its step");

  a_good_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (in_take && !idx_bad) |=> state == swc_pkg::ST_MUL)
    else $error("good index did not start the multiply");

  a_window_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !index_error) |-> release_time <= deadline_time)
    else $error("release after deadline");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && index_error) |-> (release_time == '0) && (deadline_time == '0) &&
      !overlap_bit && (group_deadline == '0))
    else $error("bad index result carries data");

endmodule

`default_nettype wire

FILE: bench/tb_pd2_subtask_window_calc_unit.sv
// self-checking testbench for pd2_subtask_window_calc_unit
// depends on swc_pkg and the rtl of the unit; needs no files or arguments
`default_nettype none

module tb_pd2_subtask_window_calc_unit;

  localparam int ITEM_TARGET  = 650;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_WAIT     = 13;
  // settle time after the last result
  localparam int TAIL_CYCLES  = 64;

  // one result transaction as the unit should produce it
  typedef struct packed {
    logic [swc_pkg::QW-1:0] rel;
    logic [swc_pkg::QW-1:0] dl;
    logic                   ovl;
    logic [swc_pkg::QW-1:0] gd;
    logic                   err;
  } subtask_window_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [swc_pkg::CFG_IDX_W-1:0] cfg_index = swc_pkg::CFG_EXEC;
  logic [swc_pkg::QW-1:0] cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [swc_pkg::QW-1:0] subtask_index = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [swc_pkg::QW-1:0] release_time;
  logic [swc_pkg::QW-1:0] deadline_time;
  logic          overlap_bit;
  logic [swc_pkg::QW-1:0] group_deadline;
  logic          index_error;

  pd2_subtask_window_calc_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .subtask_index  (subtask_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .release_time   (release_time),
    .deadline_time  (deadline_time),
    .overlap_bit    (overlap_bit),
    .group_deadline (group_deadline),
    .index_error    (index_error)
  );

  // 20 unit clock period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: shadow registers and the running group deadline minimum
  logic [swc_pkg::QW-1:0] exec_q;
  logic [swc_pkg::QW-1:0] period_q;
  logic [swc_pkg::QW-1:0] min_gd;

  subtask_window_t window_q[$];   // predicted windows, oldest first
  subtask_window_t got_window;
  int            items_sent = 0;
  int            fail_count = 0;
  int            cycle_count = 0;

  // idling controls for the sender (tx_idle) and the receiver (rx_idle, rx_hold_cycles)
  bit            tx_idle = 1'b1;
  bit            rx_idle = 1'b1;
  int            rx_hold_cycles = 0;

  // ---------------------------------------------------------------------------
  // window predictor: release, deadline, b bit and group deadline of one index
  // ---------------------------------------------------------------------------
  function automatic subtask_window_t predict_window(input logic [swc_pkg::QW-1:0] idx);
    subtask_window_t w;
    longint unsigned i, e, p, prod, r, d;
    bit lite;
    w = '0;
    i = idx;
    e = exec_q;
    p = period_q;
    // zero or above E, which also covers E of zero: flag only, state untouched
    if (i == 0 || i > e) begin
      w.err = 1'b1;
      return w;
    end
    // index E starts a new job, minimum reloads with P
    if (i == e)
      min_gd = period_q;
    // with i <= E both values stay at or below P, so they fit in 16 bits
    r    = ((i - 1) * p) / e;
    prod = i * p;
    d    = prod / e;
    if (prod % e != 0)
      d = d + 1;
    w.rel = swc_pkg::QW'(r);
    w.dl  = swc_pkg::QW'(d);
    lite  = (2 * e) < p;
    if (lite) begin
      // light task: no b bit, no group deadline, minimum cleared
      min_gd = '0;
    end else begin
      w.ovl = (i != e) && (prod % e != 0);
      w.gd  = min_gd;
      if (!w.ovl && d < min_gd) begin
        min_gd = swc_pkg::QW'(d);
        w.gd   = swc_pkg::QW'(d);
      end
      // window of length 3 pulls the minimum to d - 1
      if (d >= r && (d - r) == 3 && (d - 1) < min_gd)
        min_gd = swc_pkg::QW'(d - 1);
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: every accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [swc_pkg::QW-1:0] want,
                             input logic [swc_pkg::QW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (window_q.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_count++;
      end else begin
        got_window = window_q.pop_front();
        check_field("release_time", got_window.rel, release_time);
        check_field("deadline_time", got_window.dl, deadline_time);
        check_field("overlap_bit", swc_pkg::QW'(got_window.ovl), swc_pkg::QW'(overlap_bit));
        check_field("group_deadline", got_window.gd, group_deadline);
        check_field("index_error", swc_pkg::QW'(got_window.err), swc_pkg::QW'(index_error));
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("pd2_subtask_window_calc_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall before each result while rx_idle is set, plus an optional long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        // long hold-off so the unit backs up and stalls its input
        out_stall = 1'b1;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      n = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      // stall is low, so the first valid edge is an accepted transaction
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers; each starts and ends at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_subtask(input logic [swc_pkg::QW-1:0] idx);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    subtask_index = idx;
    do @(posedge clk); while (in_stall !== 1'b0);
    // accepted at this edge, predict with the configuration now in force
    window_q.push_back(predict_window(idx));
    items_sent++;
    @(negedge clk);
  endtask

  // drop valid and wait until every predicted result has come back
  task automatic wait_idle();
    in_valid = 1'b0;
    while (window_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [swc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [swc_pkg::QW-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == swc_pkg::CFG_EXEC)
      exec_q = value;
    else
      period_q = value;
  endtask

  task automatic set_task(input logic [swc_pkg::QW-1:0] e, input logic [swc_pkg::QW-1:0] p);
    wait_idle();
    write_reg(swc_pkg::CFG_EXEC, e);
    write_reg(swc_pkg::CFG_PERIOD, p);
  endtask

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // reset values E = P = 1, plus bad indices at both ends
  task automatic test_reset_values();
    send_subtask(16'd1);
    send_subtask(16'd0);
    send_subtask(16'hFFFF);
  endtask

  // widest registers and indices, P below E, and the lightest task
  task automatic test_extremes();
    set_task(16'hFFFF, 16'hFFFF);
    send_subtask(16'hFFFF);
    send_subtask(16'd1);
    set_task(16'hFFFF, 16'd1);
    send_subtask(16'hFFFF);
    send_subtask(16'h8000);
    set_task(16'd1, 16'hFFFF);
    send_subtask(16'd1);
  endtask

  // E of zero turns every index into a bad index
  task automatic test_zero_exec();
    set_task(16'd0, 16'd5);
    send_subtask(16'd1);
  endtask

  // light task, 2E < P
  task automatic test_light_task();
    set_task(16'd2, 16'd5);
    send_subtask(16'd2);
    send_subtask(16'd1);
  endtask

  // heavy task with b bits and a window of length 3
  task automatic test_heavy_group();
    set_task(16'd4, 16'd7);
    for (int i = 4; i >= 1; i--)
      send_subtask(swc_pkg::QW'(i));
  endtask

  // period change mid job leaves the running minimum alone
  task automatic test_register_change();
    set_task(16'd5, 16'd8);
    send_subtask(16'd5);
    wait_idle();
    write_reg(swc_pkg::CFG_PERIOD, 16'd9);
    send_subtask(16'd4);
    send_subtask(16'd3);
  endtask

  // indices out of order use the current minimum
  task automatic test_out_of_order();
    set_task(16'd6, 16'd10);
    send_subtask(16'd2);
    send_subtask(16'd6);
    send_subtask(16'd1);
    send_subtask(16'd4);
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    set_task(16'd9, 16'd13);
    tx_idle = 1'b0;
    rx_hold_cycles = 400;
    for (int i = 9; i >= 1; i--)
      send_subtask(swc_pkg::QW'(i));
    tx_idle = 1'b1;
  endtask

  // sender stops until everything is back, then resumes mid job
  task automatic test_sender_pause();
    set_task(16'd7, 16'd11);
    send_subtask(16'd7);
    send_subtask(16'd6);
    wait_idle();
    for (int i = 5; i >= 1; i--)
      send_subtask(swc_pkg::QW'(i));
  endtask

  // ---------------------------------------------------------------------------
  // random jobs: mostly descending sequences from E, some noise
  // ---------------------------------------------------------------------------
  task automatic test_random_jobs();
    int e, p, len, mode;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin
          e = $urandom_range(1, 65535);
          p = $urandom_range(1, 65535);
        end
        1: begin
          // heavy task with wide values
          e = $urandom_range(1, 65535);
          p = $urandom_range(e, (2 * e > 65535) ? 65535 : 2 * e);
        end
        2: begin
          e = $urandom_range(1, 24);
          p = $urandom_range(1, e);
        end
        default: begin
          e = $urandom_range(1, 24);
          p = $urandom_range(e, 3 * e + 2);
        end
      endcase
      set_task(swc_pkg::QW'(e), swc_pkg::QW'(p));

      // idling mode of this job, some jobs run flat out
      mode    = $urandom_range(0, 3);
      tx_idle = (mode != 0);
      rx_idle = (mode != 0) && (mode != 1);

      len = (e <= 32) ? e : $urandom_range(4, 24);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          case ($urandom_range(0, 3))
            0: send_subtask('0);
            1: send_subtask(swc_pkg::QW'($urandom));
            2: if (e < 65535) send_subtask(swc_pkg::QW'($urandom_range(e + 1, 65535)));
            default: send_subtask(swc_pkg::QW'($urandom_range(1, e)));
          endcase
        end
        send_subtask(swc_pkg::QW'(e - k));
      end
      // long jobs cut short still finish on their last subtasks
      if (len < e)
        for (int i = $urandom_range(1, 3); i >= 1; i--)
          send_subtask(swc_pkg::QW'(i));
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // predictor state after reset
    exec_q   = 16'd1;
    period_q = 16'd1;
    min_gd   = 16'd1;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_reset_values();
    test_extremes();
    test_zero_exec();
    test_light_task();
    test_heavy_group();
    test_register_change();
    test_out_of_order();
    test_backpressure();
    test_sender_pause();
    test_random_jobs();

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && window_q.size() == 0) begin
      $display("pd2_subtask_window_calc_unit: match");
    end else begin
      $display("pd2_subtask_window_calc_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
